// ===== rtl/core/mtc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtc_pkg
// shared types, character constants and code tables of the morse text codec
// ----------------------------------------------------------------------------
package mtc_pkg;

  localparam int MAX_RES = 8;
  localparam int CNT_W   = 4;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_0     = 8'h30;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  // dash = 1, first symbol in the highest used bit
  localparam logic [4:0] LETTER_PAT [26] = '{
    5'b01,   5'b1000, 5'b1010, 5'b100,  5'b0,    5'b0010, 5'b110,
    5'b0000, 5'b00,   5'b0111, 5'b101,  5'b0100, 5'b11,   5'b10,
    5'b111,  5'b0110, 5'b1101, 5'b010,  5'b000,  5'b1,    5'b001,
    5'b0001, 5'b011,  5'b1001, 5'b1011, 5'b1100
  };
  localparam logic [2:0] LETTER_LEN [26] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
    3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
  };
  localparam logic [4:0] DIGIT_PAT [10] = '{
    5'b11111, 5'b01111, 5'b00111, 5'b00011, 5'b00001,
    5'b00000, 5'b10000, 5'b11000, 5'b11100, 5'b11110
  };

  typedef struct packed {
    logic [MAX_RES-1:0][7:0] chars;
    logic [CNT_W-1:0]        count;
  } burst_t;

  typedef struct packed {
    logic   push;
    burst_t burst;
  } push_t;

  typedef struct packed {
    logic   valid;
    burst_t burst;
  } head_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] len;
    logic [4:0] pat;
  } code_t;

  // character to its code, hit low for anything but A-Z and 0-9
  function automatic code_t enc_code(input logic [7:0] c);
    code_t r;
    r = '0;
    for (int k = 0; k < 26; k++) begin
      if (c == 8'(CH_A + k)) begin
        r.hit = 1'b1;
        r.len = LETTER_LEN[k];
        r.pat = LETTER_PAT[k];
      end
    end
    for (int k = 0; k < 10; k++) begin
      if (c == 8'(CH_0 + k)) begin
        r.hit = 1'b1;
        r.len = 3'd5;
        r.pat = DIGIT_PAT[k];
      end
    end
    return r;
  endfunction

  // token to character, bit 8 is the hit flag
  function automatic logic [8:0] token_lookup(input logic [4:0] pat, input logic [2:0] len);
    logic [8:0] r;
    r = '0;
    if (len == 3'd5) begin
      for (int k = 0; k < 10; k++) begin
        if (pat == DIGIT_PAT[k]) r = {1'b1, 8'(CH_0 + k)};
      end
    end else if (len != 3'd0 && len < 3'd5) begin
      for (int k = 0; k < 26; k++) begin
        if (len == LETTER_LEN[k] && pat == LETTER_PAT[k]) r = {1'b1, 8'(CH_A + k)};
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/mtc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtc_front
// accepts words, keeps the decode token state and builds a character burst
// ----------------------------------------------------------------------------
module mtc_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          mode,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    in_char,
  input  logic          end_of_text,
  input  logic          q_full,
  output mtc_pkg::push_t push
);
  import mtc_pkg::*;

  logic [4:0] tok_pat, tok_pat_next;
  logic [2:0] tok_len, tok_len_next;
  logic       tok_long, tok_long_next;
  logic [3:0] space_run, space_run_next;

  logic       accept;
  code_t      enc;
  logic [4:0] align;
  logic [8:0] cur_hit, new_hit;
  logic       is_sp, is_nl, is_ows, is_sym;
  logic [4:0] cand_en;
  logic [4:0][7:0] cand_ch;
  logic [CNT_W-1:0] n;
  burst_t     burst;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    is_sp  = (in_char == CH_SPACE);
    is_nl  = (in_char == CH_NL);
    is_ows = (in_char == CH_TAB) || (in_char == CH_CR) ||
             (in_char == CH_VT) || (in_char == CH_FF);
    is_sym = !(is_sp || is_nl || is_ows);

    tok_pat_next   = tok_pat;
    tok_len_next   = tok_len;
    tok_long_next  = tok_long;
    space_run_next = space_run;

    if (is_sp) begin
      tok_pat_next  = '0;
      tok_len_next  = '0;
      tok_long_next = 1'b0;
      if (space_run < 4'd8) space_run_next = space_run + 4'd1;
    end else if (is_nl || is_ows) begin
      tok_pat_next   = '0;
      tok_len_next   = '0;
      tok_long_next  = 1'b0;
      space_run_next = '0;
    end else begin
      space_run_next = '0;
      if (!tok_long) begin
        if (tok_len >= 3'd5 || (in_char != CH_DOT && in_char != CH_DASH)) begin
          tok_long_next = 1'b1;
        end else begin
          tok_pat_next = {tok_pat[3:0], in_char == CH_DASH};
          tok_len_next = tok_len + 3'd1;
        end
      end
    end

    cur_hit = token_lookup(tok_pat, tok_len);
    new_hit = token_lookup(tok_pat_next, tok_len_next);

    // candidates in emission order
    cand_en[0] = !is_sym && cur_hit[8] && !tok_long;
    cand_ch[0] = cur_hit[7:0];
    cand_en[1] = !is_sp && (space_run == 4'd7);
    cand_ch[1] = CH_SPACE;
    cand_en[2] = is_nl;
    cand_ch[2] = CH_NL;
    cand_en[3] = is_sym && end_of_text && new_hit[8] && !tok_long_next;
    cand_ch[3] = new_hit[7:0];
    cand_en[4] = is_sp && end_of_text && (space_run_next == 4'd7);
    cand_ch[4] = CH_SPACE;

    if (end_of_text) begin
      tok_pat_next   = '0;
      tok_len_next   = '0;
      tok_long_next  = 1'b0;
      space_run_next = '0;
    end

    burst = '0;
    n     = '0;
    enc   = enc_code(in_char);
    align = 5'(enc.pat << (3'd5 - enc.len));

    if (mode == MODE_ENCODE) begin
      if (enc.hit) begin
        for (int i = 0; i < MAX_RES; i++) burst.chars[i] = CH_SPACE;
        for (int i = 0; i < 5; i++) begin
          if (3'(i) < enc.len) burst.chars[i] = align[4-i] ? CH_DASH : CH_DOT;
        end
        burst.count = CNT_W'(enc.len) + CNT_W'(3);
      end else if (is_sp) begin
        for (int i = 0; i < 4; i++) burst.chars[i] = CH_SPACE;
        burst.count = CNT_W'(4);
      end else if (is_nl) begin
        burst.chars[0] = CH_NL;
        burst.count    = CNT_W'(1);
      end
    end else begin
      for (int k = 0; k < 5; k++) begin
        if (cand_en[k]) begin
          burst.chars[n[2:0]] = cand_ch[k];
          n = n + CNT_W'(1);
        end
      end
      burst.count = n;
    end

    push.burst = burst;
    push.push  = accept && (burst.count != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_pat   <= '0;
      tok_len   <= '0;
      tok_long  <= 1'b0;
      space_run <= '0;
    end else if (accept && mode == MODE_DECODE) begin
      tok_pat   <= tok_pat_next;
      tok_len   <= tok_len_next;
      tok_long  <= tok_long_next;
      space_run <= space_run_next;
    end
  end

endmodule

// ===== rtl/core/mtc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtc_queue
// short fifo of character bursts between front and back
// ----------------------------------------------------------------------------
module mtc_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  mtc_pkg::push_t push,
  input  logic           pop,
  output logic           full,
  output mtc_pkg::head_t head
);
  import mtc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LVL_W = $clog2(DEPTH + 1);

  burst_t           mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [LVL_W-1:0] level;

  assign full       = (level == LVL_W'(DEPTH));
  assign head.valid = (level != '0);
  assign head.burst = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.push) mem[wr_ptr] <= push.burst;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push.push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (pop)       rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      if (push.push && !pop)      level <= level + LVL_W'(1);
      else if (pop && !push.push) level <= level - LVL_W'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push.push |-> !full)
    else $error("burst pushed into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> head.valid)
    else $error("burst popped from empty queue");
  a_level_range: assert property (@(posedge clk) disable iff (rst) level <= LVL_W'(DEPTH))
    else $error("queue level out of range");
  a_head_nonempty: assert property (@(posedge clk) disable iff (rst)
    head.valid |-> head.burst.count != '0)
    else $error("empty burst at queue head");

endmodule

// ===== rtl/core/mtc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtc_back
// walks the head burst and hands out one character per cycle while out_stall is low
// ----------------------------------------------------------------------------
module mtc_back (
  input  logic           clk,
  input  logic           rst,
  input  mtc_pkg::head_t head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_char,
  output logic           last_of_run
);
  import mtc_pkg::*;

  logic [2:0] idx;
  logic       take;

  assign out_valid   = head.valid;
  assign out_char    = head.burst.chars[idx];
  assign last_of_run = (CNT_W'(idx) + CNT_W'(1) == head.burst.count);
  assign take        = out_valid && !out_stall;
  assign pop         = take && last_of_run;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (take) begin
      idx <= last_of_run ? '0 : idx + 3'd1;
    end
  end

endmodule

// ===== rtl/core/morse_text_codec.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morse_text_codec
// international morse text codec, encode or decode chosen by the mode register
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_stall carry one word (in_char, end_of_text);
//   the word is taken on a clock edge with in_valid high and in_stall low.
//   output channel: out_valid / out_stall carry one word (out_char,
//   last_of_run); last_of_run marks the final character caused by an input.
//   cfg_we / cfg_wdata write the mode bit (0 encode, 1 decode) while idle.
// throughput
//   an input word is classified in the cycle it is taken and its burst of up
//   to eight characters is queued; its first character is offered once the
//   bursts ahead of it have drained. the output side gives one character
//   per cycle while out_stall is low, and the input side takes one word per
//   cycle while the queue is not full; the output port sets the rate.
// reset
//   rst clears the mode to encode, the decode token and space run state and
//   empties the burst queue.
// stall
//   out_stall holds the current character; input is taken until the queue
//   of QUEUE_DEPTH bursts fills, then in_stall rises.
// ----------------------------------------------------------------------------
module morse_text_codec #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char,
  input  logic       end_of_text,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       last_of_run
);
  import mtc_pkg::*;

  logic  mode;
  logic  q_full;
  logic  pop;
  push_t push;
  head_t head;

  // mode register; the user must write it only while the block is idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_ENCODE;
    end else if (cfg_we) begin
      mode <= cfg_wdata;
    end
  end

  // front: takes words, tracks decode token and space run, builds bursts
  mtc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .mode        (mode),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_char     (in_char),
    .end_of_text (end_of_text),
    .q_full      (q_full),
    .push        (push)
  );

  // queue of bursts so the two sides stall apart
  mtc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .full (q_full),
    .head (head)
  );

  // back: serialises the head burst one character a cycle while out_stall is low
  mtc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_char    (out_char),
    .last_of_run (last_of_run)
  );

endmodule
